// ===== hdl/bounded_deque_with_sort_macros.svh =====
// Assertion macros shared by the deque checker.
`ifndef BOUNDED_DEQUE_WITH_SORT_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SORT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDQS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: property violated");

// Next-cycle implication, disabled while reset is asserted.
`define BDQS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: property violated");

`endif

// ===== hdl/bdqs_pkg.sv =====
// Shared types and constants of the bounded deque with sort.
package bdqs_pkg;

	localparam int WORD_W = 32;
	localparam int FUNC_W = 3;
	localparam int CNT_OUT_W = 5;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_FRONT = 3'd0,
		FN_PUSH_BACK  = 3'd1,
		FN_POP_FRONT  = 3'd2,
		FN_POP_BACK   = 3'd3,
		FN_SORT       = 3'd4,
		FN_QUERY      = 3'd5
	} func_t;

endpackage

// ===== hdl/bdqs_ifs.sv =====
// Request and response channel interfaces of the bounded deque with sort.
interface bdqs_in_if;
	logic                               valid;
	logic                               ready;
	logic [bdqs_pkg::FUNC_W-1:0]        func;
	bdqs_pkg::word_t                    value;

	modport source (output valid, output func, output value, input ready);
	modport sink   (input valid, input func, input value, output ready);
endinterface

interface bdqs_out_if;
	logic                               valid;
	logic                               ready;
	logic                               ok;
	bdqs_pkg::word_t                    front_value;
	bdqs_pkg::word_t                    back_value;
	logic [bdqs_pkg::CNT_OUT_W-1:0]     count;
	logic                               is_empty;

	modport source (output valid, output ok, output front_value, output back_value,
		output count, output is_empty, input ready);
	modport sink   (input valid, input ok, input front_value, input back_value,
		input count, input is_empty, output ready);
endinterface

// ===== hdl/bdqs_ring.sv =====
// Circular entry memory: maps logical positions through the head pointer.
module bdqs_ring #(
	parameter int CAPACITY = 16,
	parameter int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic            clk,
	input  logic [AW-1:0]   head,
	input  logic [AW-1:0]   rd_idx,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_idx,
	input  bdqs_pkg::word_t wr_data,
	output bdqs_pkg::word_t rd_data
);

	localparam logic [AW:0] CAP_W = (AW+1)'(CAPACITY);

	bdqs_pkg::word_t mem [CAPACITY];
	bdqs_pkg::word_t rd_data_q;
	logic [AW:0]     rd_sum, wr_sum;
	logic [AW-1:0]   rd_phys, wr_phys;

	// Wrap head + position back into the array range.
	always_comb begin
		rd_sum = {1'b0, head} + {1'b0, rd_idx};
		wr_sum = {1'b0, head} + {1'b0, wr_idx};
		if (rd_sum >= CAP_W) begin
			rd_sum = rd_sum - CAP_W;
		end
		if (wr_sum >= CAP_W) begin
			wr_sum = wr_sum - CAP_W;
		end
		rd_phys = rd_sum[AW-1:0];
		wr_phys = wr_sum[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_phys] <= wr_data;
		end
		rd_data_q <= mem[rd_phys];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/bounded_deque_with_sort.sv =====
// Top level of the bounded deque of signed words with in-place ascending sort.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+--------------------------------------------
//  req     | in  | valid / ready | func, value
//  rsp     | out | valid / ready | ok, front_value, back_value, count, is_empty
//
// Push, query, sort of fewer than two entries, refused requests and pops that empty
// the deque go straight to the finishing step (ST_DONE), which raises response valid
// through the output register; the next request can transfer once it has. Other pops
// first fetch the new front or back word in ST_FETCH_FRONT or ST_FETCH_BACK through
// the memory's single read port. A sort makes one compare per cycle on the read port,
// fetches each pass start in ST_SORT_RDI and ST_SORT_GETI, swaps in ST_SORT_SWP1 and
// ST_SORT_SWP2, and refetches the ends in ST_REF0 to ST_REF2. Reset clears the state,
// the count, the head pointer and response valid; the entry memory is not swept.
// A waiting response does not block the next request transfer; it only holds the
// finishing step until the output register frees up.
module bounded_deque_with_sort #(
	parameter int CAPACITY = 16
) (
	input logic           clk,
	input logic           arst_n,
	bdqs_in_if.sink       req,
	bdqs_out_if.source    rsp
);

	localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int CW1 = CW + 1;
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
	localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH_FRONT,
		ST_FETCH_BACK,
		ST_SORT_RDI,
		ST_SORT_GETI,
		ST_SORT_CMP,
		ST_SORT_SWP1,
		ST_SORT_SWP2,
		ST_REF0,
		ST_REF1,
		ST_REF2,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       head_q;
	bdqs_pkg::word_t     front_q, back_q;
	logic                ok_q;

	// Sort bookkeeping: pass index, scan index, best position and the two words
	// that trade places at the end of a pass.
	logic [AW-1:0]       i_q, j_q, best_q;
	bdqs_pkg::word_t     bestval_q, ival_q;

	// Output register
	logic                rsp_valid_q;
	logic                rsp_ok_q;
	bdqs_pkg::word_t     rsp_front_q, rsp_back_q;
	logic [bdqs_pkg::CNT_OUT_W-1:0] rsp_count_q;
	logic                rsp_empty_q;

	logic                req_xfer;
	bdqs_pkg::func_t     func;
	logic                is_full, is_empty;
	logic [CW-1:0]       count_m1, count_m2;
	logic [AW-1:0]       head_inc, head_dec;
	logic [CW1-1:0]      j_next_w, i_next2_w, count_w;
	logic [CW+4:0]       count_ext;

	logic [AW-1:0]       rd_idx, wr_idx;
	logic                wr_en;
	bdqs_pkg::word_t     wr_data, rd_data;

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign func      = bdqs_pkg::func_t'(req.func);

	assign is_full   = (count_q == CAP_CNT);
	assign is_empty  = (count_q == '0);
	assign count_m1  = count_q - CW'(1);
	assign count_m2  = count_q - CW'(2);
	assign head_inc  = (head_q == LAST) ? '0 : head_q + AW'(1);
	assign head_dec  = (head_q == '0) ? LAST : head_q - AW'(1);
	assign count_w   = CW1'(count_q);
	assign j_next_w  = CW1'(j_q) + CW1'(1);
	assign i_next2_w = CW1'(i_q) + CW1'(2);
	assign count_ext = {5'b0, count_q};

	// Memory port steering: positions are logical, counted from the front.
	always_comb begin
		rd_idx  = '0;
		wr_en   = 1'b0;
		wr_idx  = '0;
		wr_data = req.value;
		case (state_q)
			ST_IDLE: begin
				// Pops prefetch the word that becomes the new end.
				if (func == bdqs_pkg::FN_POP_FRONT) begin
					rd_idx = AW'(1);
				end else if (func == bdqs_pkg::FN_POP_BACK) begin
					rd_idx = count_m2[AW-1:0];
				end
				if (req_xfer && !is_full) begin
					if (func == bdqs_pkg::FN_PUSH_FRONT) begin
						// One place before the head, i.e. the new head.
						wr_en  = 1'b1;
						wr_idx = LAST;
					end else if (func == bdqs_pkg::FN_PUSH_BACK) begin
						wr_en  = 1'b1;
						wr_idx = count_q[AW-1:0];
					end
				end
			end
			ST_SORT_RDI:  rd_idx = i_q;
			ST_SORT_GETI: rd_idx = i_q + AW'(1);
			ST_SORT_CMP:  rd_idx = j_q + AW'(1);
			ST_SORT_SWP1: begin
				wr_en   = 1'b1;
				wr_idx  = i_q;
				wr_data = bestval_q;
			end
			ST_SORT_SWP2: begin
				wr_en   = 1'b1;
				wr_idx  = best_q;
				wr_data = ival_q;
			end
			ST_REF0: rd_idx = '0;
			ST_REF1: rd_idx = count_m1[AW-1:0];
			default: rd_idx = '0;
		endcase
	end

	bdqs_ring #(
		.CAPACITY (CAPACITY),
		.AW       (AW)
	) u_ring (
		.clk     (clk),
		.head    (head_q),
		.rd_idx  (rd_idx),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Drop the response once it has been taken, unless the finishing step
			// loads the next one in the same cycle.
			if (rsp.valid && rsp.ready && (state_q != ST_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						state_q <= ST_DONE;
						case (func)
							bdqs_pkg::FN_PUSH_FRONT: begin
								if (is_full) begin
									ok_q <= 1'b0;
								end else begin
									ok_q    <= 1'b1;
									head_q  <= head_dec;
									count_q <= count_q + CW'(1);
									front_q <= req.value;
									if (is_empty) begin
										back_q <= req.value;
									end
								end
							end
							bdqs_pkg::FN_PUSH_BACK: begin
								if (is_full) begin
									ok_q <= 1'b0;
								end else begin
									ok_q    <= 1'b1;
									count_q <= count_q + CW'(1);
									back_q  <= req.value;
									if (is_empty) begin
										front_q <= req.value;
									end
								end
							end
							bdqs_pkg::FN_POP_FRONT: begin
								if (is_empty) begin
									ok_q <= 1'b0;
								end else begin
									ok_q    <= 1'b1;
									head_q  <= head_inc;
									count_q <= count_m1;
									if (count_q >= CW'(2)) begin
										state_q <= ST_FETCH_FRONT;
									end
								end
							end
							bdqs_pkg::FN_POP_BACK: begin
								if (is_empty) begin
									ok_q <= 1'b0;
								end else begin
									ok_q    <= 1'b1;
									count_q <= count_m1;
									if (count_q >= CW'(2)) begin
										state_q <= ST_FETCH_BACK;
									end
								end
							end
							bdqs_pkg::FN_SORT: begin
								ok_q <= 1'b1;
								if (count_q >= CW'(2)) begin
									i_q     <= '0;
									state_q <= ST_SORT_RDI;
								end
							end
							bdqs_pkg::FN_QUERY: begin
								ok_q <= 1'b1;
							end
							default: begin
								ok_q <= 1'b0;
							end
						endcase
					end
				end
				ST_FETCH_FRONT: begin
					front_q <= rd_data;
					state_q <= ST_DONE;
				end
				ST_FETCH_BACK: begin
					back_q  <= rd_data;
					state_q <= ST_DONE;
				end
				ST_SORT_RDI: begin
					state_q <= ST_SORT_GETI;
				end
				ST_SORT_GETI: begin
					// Word at the pass start is the first candidate.
					ival_q    <= rd_data;
					bestval_q <= rd_data;
					best_q    <= i_q;
					j_q       <= i_q + AW'(1);
					state_q   <= ST_SORT_CMP;
				end
				ST_SORT_CMP: begin
					if (rd_data < bestval_q) begin
						bestval_q <= rd_data;
						best_q    <= j_q;
					end
					if (j_next_w < count_w) begin
						j_q <= j_q + AW'(1);
					end else begin
						state_q <= ST_SORT_SWP1;
					end
				end
				ST_SORT_SWP1: begin
					state_q <= ST_SORT_SWP2;
				end
				ST_SORT_SWP2: begin
					i_q <= i_q + AW'(1);
					if (i_next2_w < count_w) begin
						state_q <= ST_SORT_RDI;
					end else begin
						state_q <= ST_REF0;
					end
				end
				ST_REF0: begin
					state_q <= ST_REF1;
				end
				ST_REF1: begin
					front_q <= rd_data;
					state_q <= ST_REF2;
				end
				ST_REF2: begin
					back_q  <= rd_data;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Advance only when the output register is free or being drained.
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_ok_q    <= ok_q;
						rsp_front_q <= is_empty ? '0 : front_q;
						rsp_back_q  <= is_empty ? '0 : back_q;
						rsp_count_q <= count_ext[bdqs_pkg::CNT_OUT_W-1:0];
						rsp_empty_q <= is_empty;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = rsp_ok_q;
	assign rsp.front_value = rsp_front_q;
	assign rsp.back_value  = rsp_back_q;
	assign rsp.count       = rsp_count_q;
	assign rsp.is_empty    = rsp_empty_q;

endmodule

// ===== hdl/bdqs_check.sv =====
// Port-level checker for the bounded deque with sort, bound to the top level.
`include "bounded_deque_with_sort_macros.svh"

module bdqs_check (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic                             rsp_ok,
	input bdqs_pkg::word_t                  rsp_front_value,
	input bdqs_pkg::word_t                  rsp_back_value,
	input logic [bdqs_pkg::CNT_OUT_W-1:0]   rsp_count,
	input logic                             rsp_is_empty
);

	logic ends_zero;
	logic [2*bdqs_pkg::WORD_W+bdqs_pkg::CNT_OUT_W+1:0] rsp_payload;

	assign ends_zero   = (rsp_front_value == '0) && (rsp_back_value == '0) && (rsp_count == '0);
	assign rsp_payload = {rsp_ok, rsp_front_value, rsp_back_value, rsp_count, rsp_is_empty};

	// An empty deque reports zero ends and a zero count.
	`BDQS_ASSERT_IMP(a_empty_zero, clk, arst_n, rsp_valid && rsp_is_empty, ends_zero)

	// One request at a time: a transfer closes the request side for the next cycle.
	`BDQS_ASSERT_NXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready)

	// A stalled response holds.
	`BDQS_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind bounded_deque_with_sort bdqs_check u_bdqs_check (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_ok          (rsp.ok),
	.rsp_front_value (rsp.front_value),
	.rsp_back_value  (rsp.back_value),
	.rsp_count       (rsp.count),
	.rsp_is_empty    (rsp.is_empty)
);

// ===== sim/bdqs_checker.sv =====
// Response checker for the bounded deque with sort: tracks the deque and compares each response.
module bdqs_checker #(
	parameter int CAPACITY = 16
) (
	input logic  clk,
	input logic  arst_n,
	bdqs_in_if   req,
	bdqs_out_if  rsp,
	output int   errors,
	output int   pending
);

	typedef struct packed {
		logic                           ok;
		bdqs_pkg::word_t                front_value;
		bdqs_pkg::word_t                back_value;
		logic [bdqs_pkg::CNT_OUT_W-1:0] count;
		logic                           is_empty;
	} deque_status_t;

	bdqs_pkg::word_t held [CAPACITY];
	int              held_cnt = 0;
	int              err_cnt = 0;
	int              pending_q = 0;
	deque_status_t   status_due_q [$];
	deque_status_t   due;

	assign errors  = err_cnt;
	assign pending = pending_q;

	task automatic report_mismatch(input string msg);
		$display("[%0t] deque response mismatch: %s", $realtime, msg);
		err_cnt++;
	endtask

	// Apply one request to the tracked deque and return the status it leaves.
	task automatic apply_request(input logic [bdqs_pkg::FUNC_W-1:0] f,
		input bdqs_pkg::word_t v, output deque_status_t st);
		bdqs_pkg::word_t key;
		int              j;
		st.ok = 1'b1;
		case (f)
			bdqs_pkg::FN_PUSH_FRONT: begin
				if (held_cnt >= CAPACITY) begin
					st.ok = 1'b0;
				end else begin
					for (int i = held_cnt; i > 0; i--)
						held[i] = held[i-1];
					held[0] = v;
					held_cnt++;
				end
			end
			bdqs_pkg::FN_PUSH_BACK: begin
				if (held_cnt >= CAPACITY) begin
					st.ok = 1'b0;
				end else begin
					held[held_cnt] = v;
					held_cnt++;
				end
			end
			bdqs_pkg::FN_POP_FRONT: begin
				if (held_cnt == 0) begin
					st.ok = 1'b0;
				end else begin
					for (int i = 0; i + 1 < held_cnt; i++)
						held[i] = held[i+1];
					held_cnt--;
				end
			end
			bdqs_pkg::FN_POP_BACK: begin
				if (held_cnt == 0)
					st.ok = 1'b0;
				else
					held_cnt--;
			end
			bdqs_pkg::FN_SORT: begin
				// signed ascending; equal words cannot be told apart
				for (int i = 1; i < held_cnt; i++) begin
					key = held[i];
					j = i;
					while (j > 0 && held[j-1] > key) begin
						held[j] = held[j-1];
						j--;
					end
					held[j] = key;
				end
			end
			bdqs_pkg::FN_QUERY: ;
			default: st.ok = 1'b0;
		endcase
		st.is_empty    = (held_cnt == 0);
		st.front_value = (held_cnt == 0) ? '0 : held[0];
		st.back_value  = (held_cnt == 0) ? '0 : held[held_cnt-1];
		st.count       = held_cnt[bdqs_pkg::CNT_OUT_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt = 0;
			status_due_q.delete();
		end else begin
			if (req.valid && req.ready) begin
				apply_request(req.func, req.value, due);
				status_due_q.insert(status_due_q.size(), due);
			end
			if (rsp.valid && rsp.ready) begin
				if (status_due_q.size() == 0) begin
					report_mismatch("response with no request outstanding");
				end else begin
					due = status_due_q[0];
					status_due_q.delete(0);
					if (rsp.ok !== due.ok)
						report_mismatch($sformatf("ok got %b want %b", rsp.ok, due.ok));
					if (rsp.front_value !== due.front_value)
						report_mismatch($sformatf("front_value got %0d want %0d",
							rsp.front_value, due.front_value));
					if (rsp.back_value !== due.back_value)
						report_mismatch($sformatf("back_value got %0d want %0d",
							rsp.back_value, due.back_value));
					if (rsp.count !== due.count)
						report_mismatch($sformatf("count got %0d want %0d",
							rsp.count, due.count));
					if (rsp.is_empty !== due.is_empty)
						report_mismatch($sformatf("is_empty got %b want %b",
							rsp.is_empty, due.is_empty));
				end
			end
		end
		pending_q <= status_due_q.size();
	end

endmodule

// ===== sim/testbench.sv =====
// Top of the bounded deque with sort testbench: clock, reset, request stimulus and verdict.
module testbench;

	localparam int CAPACITY     = 16;
	localparam int RANDOM_ITEMS = 1850;
	localparam int DRAIN_EVERY  = 400;   // pause until drained every this many requests
	localparam int LONG_HOLD    = 500;   // receiver hold-off, long enough to back up requests
	localparam int TAIL_CYCLES  = 50;    // settle time after the last response
	localparam int CYCLE_LIMIT  = 1500000;

	// func codes the block does not define; they act as a refused query
	localparam logic [bdqs_pkg::FUNC_W-1:0] FN_SPARE_A = 3'd6;
	localparam logic [bdqs_pkg::FUNC_W-1:0] FN_SPARE_B = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   pending;
	int   cycles = 0;
	int   burst_left = 0;

	bdqs_in_if  req_ch ();
	bdqs_out_if rsp_ch ();

	always #6 clk = ~clk;

	bounded_deque_with_sort #(.CAPACITY(CAPACITY)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	bdqs_checker #(.CAPACITY(CAPACITY)) u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.errors  (errors),
		.pending (pending)
	);

	// Offer one request and hold it until the transfer. Requests go out in bursts;
	// between bursts drop valid for a random gap, and sometimes skip the gap so
	// back-to-back stretches occur too. Valid stays high when the next request
	// follows at once, so it is never lowered and raised in the same step.
	task automatic offer(input logic [bdqs_pkg::FUNC_W-1:0] f, input bdqs_pkg::word_t v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.func  <= f;
		req_ch.value <= v;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// Stop offering and wait until every outstanding response has been checked.
	// The checker registers the outstanding count at the edge, so the value read here lags it.
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Watchdog: end the run if the responses stop coming.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL bounded_deque_with_sort");
		$finish;
	end

	// Receiver: alternate stretches of steady ready, light and heavy stalls.
	// Once in a while hold off for a long stretch so the block fills and
	// pushes back on the request side.
	initial begin
		int phase;
		int len;
		int stall_pct;
		rsp_ch.ready <= 1'b0;
		phase = 0;
		forever begin
			if (phase % 40 == 6) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 30;
					default: stall_pct = 75;
				endcase
				len = $urandom_range(20, 120);
				repeat (len) begin
					rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
					@(posedge clk);
				end
			end
			phase++;
		end
	end

	// Request stimulus
	initial begin
		int                            sent;
		int                            ep_len;
		int                            push_pct;
		int                            val_mode;
		int                            next_drain;
		int                            roll;
		logic [bdqs_pkg::FUNC_W-1:0]   f;
		bdqs_pkg::word_t               v;

		arst_n       <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.func  <= bdqs_pkg::FN_QUERY;
		req_ch.value <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: refused pops and a sort on an empty deque, the spare codes,
		// sort of a single entry, extreme words with a duplicate pair, then fill
		// to capacity, refused pushes when full, a full sort and both pops.
		offer(bdqs_pkg::FN_POP_FRONT, $urandom);
		offer(bdqs_pkg::FN_POP_BACK, $urandom);
		offer(bdqs_pkg::FN_SORT, $urandom);
		offer(FN_SPARE_A, $urandom);
		offer(FN_SPARE_B, $urandom);
		offer(bdqs_pkg::FN_PUSH_BACK, 32'sh7fffffff);
		offer(bdqs_pkg::FN_SORT, $urandom);
		offer(bdqs_pkg::FN_PUSH_FRONT, 32'sh80000000);
		offer(bdqs_pkg::FN_PUSH_BACK, 32'sh80000000);
		offer(bdqs_pkg::FN_SORT, $urandom);
		for (int i = 0; i < CAPACITY - 3; i++) begin
			case (i % 4)
				0: v = -1;
				1: v = 0;
				2: v = 1;
				default: v = $urandom;
			endcase
			offer((i % 2) ? bdqs_pkg::FN_PUSH_BACK : bdqs_pkg::FN_PUSH_FRONT, v);
		end
		offer(bdqs_pkg::FN_PUSH_FRONT, $urandom);
		offer(bdqs_pkg::FN_PUSH_BACK, $urandom);
		offer(bdqs_pkg::FN_SORT, $urandom);
		offer(bdqs_pkg::FN_POP_FRONT, $urandom);
		offer(bdqs_pkg::FN_POP_BACK, $urandom);
		offer(bdqs_pkg::FN_QUERY, $urandom);
		drain();

		// Random: episodes that lean toward pushing, popping or neither, so the
		// deque fills to capacity and empties again many times. Each episode
		// draws words from a full range, a narrow range (duplicates in sorts)
		// or the extremes. A few percent are spare codes as noise.
		sent = 0;
		next_drain = DRAIN_EVERY;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= next_drain) begin
				drain();
				next_drain += DRAIN_EVERY;
			end
			ep_len = $urandom_range(8, 40);
			case ($urandom_range(0, 2))
				0: push_pct = 85;
				1: push_pct = 50;
				default: push_pct = 15;
			endcase
			val_mode = $urandom_range(0, 2);
			repeat (ep_len) begin
				roll = $urandom_range(0, 99);
				if (roll < 2)
					f = $urandom_range(0, 1) ? FN_SPARE_A : FN_SPARE_B;
				else if (roll < 9)
					f = bdqs_pkg::FN_SORT;
				else if (roll < 14)
					f = bdqs_pkg::FN_QUERY;
				else if ($urandom_range(0, 99) < push_pct)
					f = $urandom_range(0, 1) ? bdqs_pkg::FN_PUSH_FRONT : bdqs_pkg::FN_PUSH_BACK;
				else
					f = $urandom_range(0, 1) ? bdqs_pkg::FN_POP_FRONT : bdqs_pkg::FN_POP_BACK;
				case (val_mode)
					0: v = $urandom;
					1: begin
						v = $urandom_range(0, 6);
						v = v - 3;
					end
					default: begin
						case ($urandom_range(0, 4))
							0: v = 32'sh80000000;
							1: v = 32'sh7fffffff;
							2: v = 0;
							3: v = -1;
							default: v = 1;
						endcase
					end
				endcase
				offer(f, v);
				sent++;
			end
		end

		// Wait out the last responses, then let the block settle.
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS bounded_deque_with_sort");
		else
			$display("FAIL bounded_deque_with_sort");
		$finish;
	end

endmodule
